@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication violated");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication violated");

`endif

@@ rtl/stb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_W           = 32;
    localparam int IDX_W           = 11;
    localparam int OP_W            = 2;
    localparam int CMD_FIFO_DEPTH  = 2;
    localparam int RES_FIFO_DEPTH  = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_SEARCH
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic signed [KEY_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [IDX_W-1:0] first_index;
        logic signed [IDX_W-1:0] last_index;
    } res_word_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_START,
        BK_PROBE,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic res_push;
    } back_stat_t;

endpackage
`default_nettype wire

@@ rtl/stb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule
`default_nettype wire

@@ rtl/stb_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stb_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

@@ rtl/stb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stb_front import stb_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic signed [KEY_W-1:0] value,
    output logic                         full,
    output logic                         cmd_valid,
    output cmd_word_t                    cmd_word,
    input  wire logic                    cmd_pop
);

    cmd_word_t               dec_word;
    logic                    dec_ok;
    logic [$bits(cmd_word_t)-1:0] q_rdata;
    logic                    q_empty;

    always_comb
    begin
        dec_word.value = value;
        dec_word.cmd   = CMD_CLEAR;
        dec_ok         = 1'b1;
        unique case (op)
            OP_CLEAR:  dec_word.cmd = CMD_CLEAR;
            OP_APPEND: dec_word.cmd = CMD_APPEND;
            OP_SEARCH: dec_word.cmd = CMD_SEARCH;
            default:   dec_ok = 1'b0;
        endcase
    end

    // drop unused op codes at the door
    stb_fifo #(
        .WIDTH ($bits(cmd_word_t)),
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && dec_ok),
        .wdata (dec_word),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign cmd_valid = !q_empty;
    assign cmd_word  = cmd_word_t'(q_rdata);

endmodule
`default_nettype wire

@@ rtl/stb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stb_back import stb_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire cmd_word_t           cmd_word,
    output logic                     cmd_pop,
    input  wire logic                pop,
    output logic                     empty,
    output logic signed [IDX_W-1:0]  first_index,
    output logic signed [IDX_W-1:0]  last_index,
    output back_stat_t               stat
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    function automatic logic [IDX_W-1:0] to_field(input logic hit, input logic [CW-1:0] idx);
        logic [XW-1:0] ext;
        begin
            ext = XW'(idx);
            to_field = hit ? ext[IDX_W-1:0] : '1;
        end
    endfunction

    back_state_t             state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           lo_reg, lo_next;
    logic [CW-1:0]           end_reg, end_next;
    logic [CW-1:0]           mid_reg, mid_next;
    logic [CW-1:0]           hit_idx_reg, hit_idx_next;
    logic                    hit_reg, hit_next;
    logic                    last_pass_reg, last_pass_next;
    logic signed [KEY_W-1:0] target_reg, target_next;
    logic [IDX_W-1:0]        first_reg, first_next;

    logic [CW-1:0]           lo_cur, end_cur, hit_idx_cur, mid_calc;
    logic                    hit_cur, more;
    logic [CW:0]             mid_sum;
    logic [KEY_W-1:0]        rd_data;
    logic signed [KEY_W-1:0] key;
    logic                    ram_we, res_push, res_full;
    res_word_t               res_word;
    res_word_t               res_out;
    logic [$bits(res_word_t)-1:0] res_rdata;

    assign key = $signed(rd_data);

    // probe outcome folded into the search window
    always_comb
    begin
        lo_cur      = lo_reg;
        end_cur     = end_reg;
        hit_cur     = hit_reg;
        hit_idx_cur = hit_idx_reg;
        if (state_reg == BK_PROBE)
        begin
            if (key == target_reg)
            begin
                hit_cur     = 1'b1;
                hit_idx_cur = mid_reg;
                if (last_pass_reg)
                begin
                    lo_cur = mid_reg + CW'(1);
                end
                else
                begin
                    end_cur = mid_reg;
                end
            end
            else if (key < target_reg)
            begin
                lo_cur = mid_reg + CW'(1);
            end
            else
            begin
                end_cur = mid_reg;
            end
        end
    end

    assign mid_sum  = {1'b0, lo_cur} + {1'b0, end_cur} - (CW + 1)'(1);
    assign mid_calc = mid_sum[CW:1];
    assign more     = (lo_cur < end_cur);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (cmd_word.cmd == CMD_SEARCH))
                begin
                    state_next = BK_START;
                end
            end
            BK_START, BK_PROBE:
            begin
                if (more)
                begin
                    state_next = BK_PROBE;
                end
                else if (!last_pass_reg)
                begin
                    state_next = BK_START;
                end
                else
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (!res_full)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        res_push       = 1'b0;
        count_next     = count_reg;
        lo_next        = lo_cur;
        end_next       = end_cur;
        mid_next       = mid_reg;
        hit_next       = hit_cur;
        hit_idx_next   = hit_idx_cur;
        last_pass_next = last_pass_reg;
        target_next    = target_reg;
        first_next     = first_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd_word.cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg < CW'(TABLE_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_SEARCH:
                        begin
                            target_next    = cmd_word.value;
                            lo_next        = '0;
                            end_next       = count_reg;
                            hit_next       = 1'b0;
                            last_pass_next = 1'b0;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            BK_START, BK_PROBE:
            begin
                if (more)
                begin
                    mid_next = mid_calc;
                end
                else if (!last_pass_reg)
                begin
                    first_next     = to_field(hit_cur, hit_idx_cur);
                    lo_next        = '0;
                    end_next       = count_reg;
                    hit_next       = 1'b0;
                    last_pass_next = 1'b1;
                end
            end
            BK_OUT:
            begin
                res_push = !res_full;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        end_reg       <= end_next;
        mid_reg       <= mid_next;
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        last_pass_reg <= last_pass_next;
        target_reg    <= target_next;
        first_reg     <= first_next;
    end

    stb_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_keys (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cmd_word.value),
        .rd_addr (mid_calc[AW-1:0]),
        .rd_data (rd_data)
    );

    assign res_word.first_index = first_reg;
    assign res_word.last_index  = to_field(hit_reg, hit_idx_reg);

    stb_fifo #(
        .WIDTH ($bits(res_word_t)),
        .DEPTH (RES_FIFO_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out       = res_word_t'(res_rdata);
    assign first_index   = res_out.first_index;
    assign last_index    = res_out.last_index;
    assign stat.busy     = (state_reg != BK_IDLE);
    assign stat.res_push = res_push;

endmodule
`default_nettype wire

@@ rtl/sorted_table_range_search_core.sv @@
// Sorted-table range search.
// Input queue: drive op and value with push; a word is taken on a clock
// edge with push high and full low. op clear empties the table, op append
// stores value at the next slot (dropped once the table holds TABLE_DEPTH
// keys), op search looks up value. The unused op code is dropped.
// Result queue: each search yields one word on first_index and last_index
// while empty is low; pop takes it. An index is -1 when the key is absent.
// The engine does clear and append as it pops the word. A search runs two
// passes, one for the first match and one for the last, where each pass makes
// at most ceil(log2(n + 1)) probes of the key memory for n stored keys; each
// probe is one registered memory read. Words are worked one at a time, in
// order.
// A two-word queue sits on each side, so the input keeps taking words while
// the engine runs and the engine keeps going while results wait. If pop stays
// low, the result queue fills, the engine holds, and full rises.
// Reset empties both queues and the table; key storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sorted_table_range_search_core import stb_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic signed [KEY_W-1:0] value,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [IDX_W-1:0]      first_index,
    output logic signed [IDX_W-1:0]      last_index
);

    logic       cmd_valid;
    logic       cmd_pop;
    cmd_word_t  cmd_word;
    back_stat_t stat;

    stb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .op        (op),
        .value     (value),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd_word  (cmd_word),
        .cmd_pop   (cmd_pop)
    );

    stb_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_word    (cmd_word),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .first_index (first_index),
        .last_index  (last_index),
        .stat        (stat)
    );

    `ASSERT_IMPLIES(a_result_from_engine, clk, rst_n, $fell(empty), $past(stat.res_push))
    `ASSERT_NEXT(a_result_shows, clk, rst_n, stat.res_push, !empty)
    `ASSERT_IMPLIES(a_full_only_when_busy, clk, rst_n, full, $past(stat.busy))

endmodule
`default_nettype wire
